// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the markup escape encoder RTL.
// Depends on nothing; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that prop holds at every rising clock edge outside reset.
`define MEE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Checks that cond implies result in the same cycle.
`define MEE_ASSERT_IMPL(label, clk, rst_n, cond, result) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (result)) \
		else $error("assertion failed");
// Checks that cond implies result in the following cycle.
`define MEE_ASSERT_NEXT(label, clk, rst_n, cond, result) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
		else $error("assertion failed");
`else
`define MEE_ASSERT(label, clk, rst_n, prop)
`define MEE_ASSERT_IMPL(label, clk, rst_n, cond, result)
`define MEE_ASSERT_NEXT(label, clk, rst_n, cond, result)
`endif
`endif

// ===== rtl/mee_pkg.sv =====
// Package of the markup escape encoder: configuration and run descriptor types,
// character constants, run kinds and the escape sequence lookup. Depends on nothing.
package mee_pkg;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_MARKUP_ENABLE  = 2'd0;
	localparam logic [1:0] REG_TAG_BEGIN_CODE = 2'd1;
	localparam logic [1:0] REG_TAG_END_CODE   = 2'd2;
	localparam logic [1:0] REG_ENTITY_CODE    = 2'd3;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// Characters used by the translation.
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_L    = 8'h6C;
	localparam logic [7:0] CH_G    = 8'h67;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_P    = 8'h70;
	localparam logic [7:0] CH_Q    = 8'h71;
	localparam logic [7:0] CH_U    = 8'h75;
	localparam logic [7:0] CH_O    = 8'h6F;

	// Kinds of output run that one input byte can cause.
	localparam logic [2:0] KIND_BYTE = 3'd0;
	localparam logic [2:0] KIND_END  = 3'd1;
	localparam logic [2:0] KIND_LT   = 3'd2;
	localparam logic [2:0] KIND_GT   = 3'd3;
	localparam logic [2:0] KIND_AMP  = 3'd4;
	localparam logic [2:0] KIND_QUOT = 3'd5;

	localparam int unsigned RUN_DEPTH = 2;

	typedef struct packed {
		logic       markup_enable;
		logic [7:0] tag_begin_code;
		logic [7:0] tag_end_code;
		logic [7:0] entity_code;
	} cfg_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       str_last;
	} run_t;

	typedef struct packed {
		logic       full;
		logic [1:0] count;
	} fifo_status_t;

	// Index of the final byte of a run of the given kind.
	function automatic logic [2:0] run_last_idx(input logic [2:0] kind);
		logic [2:0] r;
		begin
			case (kind)
				KIND_LT:   r = 3'd3;
				KIND_GT:   r = 3'd3;
				KIND_AMP:  r = 3'd4;
				KIND_QUOT: r = 3'd5;
				default:   r = 3'd0;
			endcase
			run_last_idx = r;
		end
	endfunction

	// Byte number idx of a run; single byte runs return their data byte.
	function automatic logic [7:0] seq_byte(input logic [2:0] kind, input logic [7:0] data,
			input logic [2:0] idx);
		logic [63:0] seq;
		begin
			case (kind)
				KIND_LT:   seq = {32'h0, CH_SEMI, CH_T, CH_L, CH_AMP};
				KIND_GT:   seq = {32'h0, CH_SEMI, CH_T, CH_G, CH_AMP};
				KIND_AMP:  seq = {24'h0, CH_SEMI, CH_P, CH_M, CH_A, CH_AMP};
				KIND_QUOT: seq = {16'h0, CH_SEMI, CH_T, CH_O, CH_U, CH_Q, CH_AMP};
				default:   seq = {56'h0, data};
			endcase
			seq_byte = seq[{idx, 3'b000} +: 8];
		end
	endfunction

endpackage

// ===== rtl/markup_escape_encoder.sv =====
// Top level of the markup escape encoder: configuration registers, classifier,
// run queue and output serializer. Depends on mee_pkg and assert_macros.svh.
//
// Usage: source text enters one byte per transfer on in_valid/in_stall with
// in_byte and last_in_string. Each byte yields zero to six result transfers on
// out_valid/out_stall carrying out_byte, byte_valid, run_last and string_end;
// run_last marks the final result of a byte, string_end that of a string.
// A final byte that yields no text gives one result with byte_valid low.
// One byte per cycle passes for bytes that give one result while the receiver
// does not stall; a byte with several results holds the output while its run
// is walked, and the two-entry run queue lets input continue until it fills.
// The output register is the one place bytes leave, so the rate is set by the
// serializer walking a run. Reset clears the tag and entity state, empties
// the queue and output, and loads the marker registers with their defaults.
// When the receiver stalls, the result stays unchanged and input stalls once
// the queue is full. The user must write the registers over the APB-style port
// only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module markup_escape_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mee_pkg::ADDR_W-1:0] paddr,
	input  logic [mee_pkg::DATA_W-1:0] pwdata,
	output logic [mee_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 in_byte,
	input  logic                       last_in_string,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_byte,
	output logic                       byte_valid,
	output logic                       run_last,
	output logic                       string_end
);

	mee_pkg::cfg_t         cfg;
	mee_pkg::run_t         run;
	mee_pkg::run_t         head;
	mee_pkg::fifo_status_t fifo_status;
	logic                  accept;
	logic                  push;
	logic                  pop;
	logic                  head_valid;

	// Input transfers are taken while the run queue has room.
	assign in_stall = fifo_status.full;
	assign accept   = in_valid && !in_stall;

	mee_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mee_classify u_classify (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.accept         (accept),
		.in_byte        (in_byte),
		.last_in_string (last_in_string),
		.push           (push),
		.run            (run)
	);

	mee_run_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.run_in     (run),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.status     (fifo_status)
	);

	mee_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end)
	);

	// The queue never holds more than its depth.
	`MEE_ASSERT(a_fifo_bound, clk, arst_n, fifo_status.count <= 2'(mee_pkg::RUN_DEPTH))
	// A final string byte always leaves a run behind in the queue.
	`MEE_ASSERT_NEXT(a_last_queued, clk, arst_n, accept && last_in_string, fifo_status.count != 2'd0)
	// A bare end mark is always the closing result of its string.
	`MEE_ASSERT_IMPL(a_end_mark, clk, arst_n, out_valid && !byte_valid, run_last && string_end)

endmodule

// ===== rtl/mee_regs.sv =====
// Configuration registers of the markup escape encoder behind an APB-style port.
// Depends on mee_pkg.
module mee_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mee_pkg::ADDR_W-1:0] paddr,
	input  logic [mee_pkg::DATA_W-1:0] pwdata,
	output logic [mee_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output mee_pkg::cfg_t              cfg
);

	mee_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.markup_enable  <= 1'b1;
			cfg_q.tag_begin_code <= 8'd3;
			cfg_q.tag_end_code   <= 8'd4;
			cfg_q.entity_code    <= 8'd6;
		end else if (wr_en) begin
			unique case (reg_idx)
				mee_pkg::REG_MARKUP_ENABLE:  cfg_q.markup_enable  <= pwdata[0];
				mee_pkg::REG_TAG_BEGIN_CODE: cfg_q.tag_begin_code <= pwdata[7:0];
				mee_pkg::REG_TAG_END_CODE:   cfg_q.tag_end_code   <= pwdata[7:0];
				mee_pkg::REG_ENTITY_CODE:    cfg_q.entity_code    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read data selection.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			mee_pkg::REG_MARKUP_ENABLE:  prdata = {31'h0, cfg_q.markup_enable};
			mee_pkg::REG_TAG_BEGIN_CODE: prdata = {24'h0, cfg_q.tag_begin_code};
			mee_pkg::REG_TAG_END_CODE:   prdata = {24'h0, cfg_q.tag_end_code};
			mee_pkg::REG_ENTITY_CODE:    prdata = {24'h0, cfg_q.entity_code};
			default:                     prdata = '0;
		endcase
	end

endmodule

// ===== rtl/mee_classify.sv =====
// Byte classifier of the markup escape encoder: tracks tag and entity state and
// turns each accepted byte into a run descriptor. Depends on mee_pkg.
module mee_classify (
	input  logic          clk,
	input  logic          arst_n,
	input  mee_pkg::cfg_t cfg,
	input  logic          accept,
	input  logic [7:0]    in_byte,
	input  logic          last_in_string,
	output logic          push,
	output mee_pkg::run_t run
);

	logic       inside_tag_q;
	logic       inside_entity_q;
	logic       tag_d;
	logic       entity_d;
	logic       emit;
	logic       on;
	logic [2:0] kind;
	logic [7:0] data;

	assign on = cfg.markup_enable;

	// Marker tests in priority order, then the escapes for special characters.
	always_comb begin
		emit     = 1'b0;
		kind     = mee_pkg::KIND_BYTE;
		data     = in_byte;
		tag_d    = inside_tag_q;
		entity_d = inside_entity_q;
		if (inside_tag_q) begin
			emit = on;
			if (in_byte == cfg.tag_end_code) begin
				tag_d = 1'b0;
				data  = mee_pkg::CH_GT;
			end
		end else if (inside_entity_q) begin
			emit = on;
			if (in_byte == mee_pkg::CH_SEMI) begin
				entity_d = 1'b0;
			end
		end else if (in_byte == cfg.tag_begin_code) begin
			tag_d = 1'b1;
			emit  = on;
			data  = mee_pkg::CH_LT;
		end else if (in_byte == cfg.tag_end_code) begin
			emit = on;
			data = mee_pkg::CH_GT;
		end else if (in_byte == cfg.entity_code) begin
			entity_d = 1'b1;
			emit     = on;
			data     = mee_pkg::CH_AMP;
		end else begin
			emit = 1'b1;
			if (on) begin
				case (in_byte)
					mee_pkg::CH_LT:   kind = mee_pkg::KIND_LT;
					mee_pkg::CH_GT:   kind = mee_pkg::KIND_GT;
					mee_pkg::CH_AMP:  kind = mee_pkg::KIND_AMP;
					mee_pkg::CH_QUOT: kind = mee_pkg::KIND_QUOT;
					default:          kind = mee_pkg::KIND_BYTE;
				endcase
			end
		end
		// A final byte that gives nothing still carries the end mark.
		if (last_in_string && !emit) begin
			kind = mee_pkg::KIND_END;
			data = 8'h00;
		end
		if (last_in_string) begin
			tag_d    = 1'b0;
			entity_d = 1'b0;
		end
	end

	assign push         = accept && (emit || last_in_string);
	assign run.kind     = kind;
	assign run.data     = data;
	assign run.str_last = last_in_string;

	// Tag and entity state advance on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_tag_q    <= 1'b0;
			inside_entity_q <= 1'b0;
		end else if (accept) begin
			inside_tag_q    <= tag_d;
			inside_entity_q <= entity_d;
		end
	end

endmodule

// ===== rtl/mee_run_fifo.sv =====
// Two-entry queue of run descriptors between the classifier and the serializer.
// Depends on mee_pkg.
module mee_run_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mee_pkg::run_t         run_in,
	input  logic                  pop,
	output logic                  head_valid,
	output mee_pkg::run_t         head,
	output mee_pkg::fifo_status_t status
);

	mee_pkg::run_t entry_q [mee_pkg::RUN_DEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_pop;

	assign head_valid   = (count_q != 2'd0);
	assign head         = entry_q[rd_ptr_q];
	assign do_pop       = pop && head_valid;
	assign status.full  = (count_q == 2'(mee_pkg::RUN_DEPTH));
	assign status.count = count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= run_in;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/mee_serializer.sv =====
// Serializer of the markup escape encoder: walks the head run into the output
// register one byte a cycle while the receiver does not stall. Depends on mee_pkg.
module mee_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  mee_pkg::run_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic          run_last,
	output logic          string_end
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       run_last_q;
	logic       string_end_q;
	logic       can_load;
	logic       load;
	logic       at_end;

	assign can_load = !out_valid_q || !out_stall;
	assign load     = can_load && head_valid;
	assign at_end   = (idx_q == mee_pkg::run_last_idx(head.kind));
	assign pop      = load && at_end;

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

	// Position within the current run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= head_valid;
			if (load) begin
				idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	// Output payload register, held while the receiver stalls.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= mee_pkg::seq_byte(head.kind, head.data, idx_q);
			byte_valid_q <= (head.kind != mee_pkg::KIND_END);
			run_last_q   <= at_end;
			string_end_q <= at_end && head.str_last;
		end
	end

endmodule

// ===== tb/sv/markup_escape_encoder_test.sv =====
// Self-checking testbench for the markup escape encoder: directed and random text
// strings under several marker settings, with random idle and stall bursts.
// Depends on mee_pkg and the markup_escape_encoder RTL.

module markup_escape_encoder_test;

	// Expected escaped output of the encoder, worked out per accepted input byte.
	typedef struct {
		logic [7:0] data;
		logic       valid;
		logic       last_of_byte;
		logic       last_of_string;
	} escaped_byte_t;

	class escape_tracker;
		mee_pkg::cfg_t regs;
		bit in_tag;
		bit in_entity;
		escaped_byte_t expected_bytes[$];
		int mismatch_count;
		int results_seen;

		function new();
			regs.markup_enable = 1'b1;
			regs.tag_begin_code = 8'd3;
			regs.tag_end_code = 8'd4;
			regs.entity_code = 8'd6;
			in_tag = 0;
			in_entity = 0;
			mismatch_count = 0;
			results_seen = 0;
		endfunction

		// A register write changes only the mode, never the tag or entity state.
		function void apply_reg(logic [1:0] idx, logic [7:0] value);
			case (idx)
				mee_pkg::REG_MARKUP_ENABLE:  regs.markup_enable = value[0];
				mee_pkg::REG_TAG_BEGIN_CODE: regs.tag_begin_code = value;
				mee_pkg::REG_TAG_END_CODE:   regs.tag_end_code = value;
				mee_pkg::REG_ENTITY_CODE:    regs.entity_code = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		// Escapes one accepted input byte and queues the results it causes.
		function void note_byte(logic [7:0] c, logic last);
			logic [7:0] seq[$];
			escaped_byte_t r;
			bit on;
			on = regs.markup_enable;
			seq = {};
			if (in_tag) begin
				if (c == regs.tag_end_code) begin
					in_tag = 0;
					if (on) seq.push_back(mee_pkg::CH_GT);
				end else if (on) begin
					seq.push_back(c);
				end
			end else if (in_entity) begin
				if (on) seq.push_back(c);
				if (c == mee_pkg::CH_SEMI) in_entity = 0;
			end else if (c == regs.tag_begin_code) begin
				in_tag = 1;
				if (on) seq.push_back(mee_pkg::CH_LT);
			end else if (c == regs.tag_end_code) begin
				if (on) seq.push_back(mee_pkg::CH_GT);
			end else if (c == regs.entity_code) begin
				in_entity = 1;
				if (on) seq.push_back(mee_pkg::CH_AMP);
			end else if (on) begin
				case (c)
					mee_pkg::CH_LT:   seq = {mee_pkg::CH_AMP, mee_pkg::CH_L, mee_pkg::CH_T,
						mee_pkg::CH_SEMI};
					mee_pkg::CH_GT:   seq = {mee_pkg::CH_AMP, mee_pkg::CH_G, mee_pkg::CH_T,
						mee_pkg::CH_SEMI};
					mee_pkg::CH_AMP:  seq = {mee_pkg::CH_AMP, mee_pkg::CH_A, mee_pkg::CH_M,
						mee_pkg::CH_P, mee_pkg::CH_SEMI};
					mee_pkg::CH_QUOT: seq = {mee_pkg::CH_AMP, mee_pkg::CH_Q, mee_pkg::CH_U,
						mee_pkg::CH_O, mee_pkg::CH_T, mee_pkg::CH_SEMI};
					default: seq.push_back(c);
				endcase
			end else begin
				seq.push_back(c);
			end
			foreach (seq[k]) begin
				r.data = seq[k];
				r.valid = 1'b1;
				r.last_of_byte = (k == seq.size() - 1);
				r.last_of_string = (k == seq.size() - 1) && last;
				expected_bytes.push_back(r);
			end
			// A final byte that gives no text still carries the string-end mark.
			if (seq.size() == 0 && last) begin
				r.data = 8'h00;
				r.valid = 1'b0;
				r.last_of_byte = 1'b1;
				r.last_of_string = 1'b1;
				expected_bytes.push_back(r);
			end
			if (last) begin
				in_tag = 0;
				in_entity = 0;
			end
		endfunction

		task report_mismatch(string msg);
			$display("ERROR: %s", msg);
			mismatch_count++;
		endtask

		// Compares one accepted result, field by field, with the oldest expectation.
		task check_result(logic [7:0] ob, logic bv, logic rl, logic se);
			escaped_byte_t w;
			results_seen++;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("result %0d: unexpected out_byte=%02h byte_valid=%b",
					results_seen, ob, bv));
			end else begin
				w = expected_bytes.pop_front();
				if (ob !== w.data)
					report_mismatch($sformatf("result %0d: out_byte %02h, expected %02h",
						results_seen, ob, w.data));
				if (bv !== w.valid)
					report_mismatch($sformatf("result %0d: byte_valid %b, expected %b",
						results_seen, bv, w.valid));
				if (rl !== w.last_of_byte)
					report_mismatch($sformatf("result %0d: run_last %b, expected %b",
						results_seen, rl, w.last_of_byte));
				if (se !== w.last_of_string)
					report_mismatch($sformatf("result %0d: string_end %b, expected %b",
						results_seen, se, w.last_of_string));
			end
		endtask
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [mee_pkg::ADDR_W-1:0]  paddr = '0;
	logic [mee_pkg::DATA_W-1:0]  pwdata = '0;
	logic [mee_pkg::DATA_W-1:0]  prdata;
	logic                        pready;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [7:0]                  in_byte = 8'h00;
	logic                        last_in_string = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [7:0]                  out_byte;
	logic                        byte_valid;
	logic                        run_last;
	logic                        string_end;

	escape_tracker book = new();
	bit idle_on = 1'b1;
	int bytes_sent = 0;
	int stall_left = 0;

	markup_escape_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.last_in_string(last_in_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.run_last(run_last),
		.string_end(string_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Output side: check each result transfer and stall in random bursts.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_result(out_byte, byte_valid, run_last, string_end);
		if (!idle_on) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 8);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Sends one byte, sometimes after an idle gap, and waits for its transfer.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		last_in_string <= last;
		do @(posedge clk); while (in_stall);
		book.note_byte(b, last);
		bytes_sent++;
	endtask

	// Lets every expected result arrive, then lets a byte with no result finish.
	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (book.pending() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= mee_pkg::DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		book.apply_reg(idx, value);
	endtask

	task automatic set_mode(input logic me, input logic [7:0] tb, input logic [7:0] te,
			input logic [7:0] ent);
		settle();
		write_reg(mee_pkg::REG_MARKUP_ENABLE, {7'b0, me});
		write_reg(mee_pkg::REG_TAG_BEGIN_CODE, tb);
		write_reg(mee_pkg::REG_TAG_END_CODE, te);
		write_reg(mee_pkg::REG_ENTITY_CODE, ent);
	endtask

	// Plain text leaning on the escaped characters and the current markers.
	function automatic logic [7:0] pick_text_byte();
		case ($urandom_range(0, 11))
			0: return mee_pkg::CH_LT;
			1: return mee_pkg::CH_GT;
			2: return mee_pkg::CH_AMP;
			3: return mee_pkg::CH_QUOT;
			4: return mee_pkg::CH_SEMI;
			5: return book.regs.tag_end_code;
			6: return book.regs.tag_begin_code;
			7: return book.regs.entity_code;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One random string: mostly plain text, tags and entities in sequence,
	// sometimes raw noise or a tag or entity that never closes.
	task automatic send_text();
		logic [7:0] txt[$];
		int kind;
		txt = {};
		if ($urandom_range(0, 9) < 8) begin
			repeat ($urandom_range(1, 6)) begin
				kind = $urandom_range(0, 9);
				if (kind < 5) begin
					repeat ($urandom_range(1, 3)) txt.push_back(pick_text_byte());
				end else if (kind < 8) begin
					txt.push_back(book.regs.tag_begin_code);
					repeat ($urandom_range(0, 4)) txt.push_back(8'($urandom_range(0, 255)));
					if ($urandom_range(0, 7) != 0) txt.push_back(book.regs.tag_end_code);
				end else begin
					txt.push_back(book.regs.entity_code);
					repeat ($urandom_range(0, 4)) txt.push_back(8'($urandom_range(97, 122)));
					if ($urandom_range(0, 7) != 0) txt.push_back(mee_pkg::CH_SEMI);
				end
			end
		end else begin
			repeat ($urandom_range(1, 8)) txt.push_back(pick_text_byte());
		end
		foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
	endtask

	task automatic run_text(input int count);
		int target;
		target = bytes_sent + count;
		while (bytes_sent < target) send_text();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset markers, markup on: extremes, escapes, tag and entity bodies.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(mee_pkg::CH_LT, 1'b0);
		send_byte(mee_pkg::CH_GT, 1'b0);
		send_byte(mee_pkg::CH_AMP, 1'b0);
		send_byte(mee_pkg::CH_QUOT, 1'b0);
		send_byte(8'd4, 1'b0);
		send_byte(8'd3, 1'b0);
		send_byte(mee_pkg::CH_QUOT, 1'b0);
		send_byte(8'd4, 1'b0);
		send_byte(8'd6, 1'b0);
		send_byte(mee_pkg::CH_LT, 1'b0);
		send_byte(mee_pkg::CH_SEMI, 1'b0);
		send_byte(mee_pkg::CH_SEMI, 1'b1);
		// A tag cut off by the end of the string, then fresh plain text.
		send_byte(8'd3, 1'b0);
		send_byte(8'h62, 1'b1);
		send_byte(mee_pkg::CH_AMP, 1'b1);
		run_text(60);

		// Markup off: markers and bodies vanish, empty bytes give a bare end mark.
		set_mode(1'b0, 8'd3, 8'd4, 8'd6);
		send_byte(8'd3, 1'b0);
		send_byte(8'h71, 1'b0);
		send_byte(8'd4, 1'b0);
		send_byte(mee_pkg::CH_QUOT, 1'b0);
		send_byte(8'd6, 1'b0);
		send_byte(mee_pkg::CH_SEMI, 1'b1);
		send_byte(8'd6, 1'b0);
		send_byte(8'h72, 1'b1);
		run_text(50);

		// Marker extremes, overlapping markers and markers on escaped characters.
		set_mode(1'b1, 8'h00, 8'hFF, 8'h80);
		idle_on = 1'b0;
		run_text(50);
		idle_on = 1'b1;
		set_mode(1'b0, 8'hFF, 8'h00, 8'hFF);
		run_text(50);
		set_mode(1'b1, mee_pkg::CH_LT, mee_pkg::CH_GT, mee_pkg::CH_AMP);
		run_text(50);
		set_mode(1'b1, 8'h07, 8'h07, 8'h07);
		run_text(45);
		set_mode(1'b0, mee_pkg::CH_QUOT, mee_pkg::CH_SEMI, mee_pkg::CH_SEMI);
		run_text(45);
		set_mode(1'b1, 8'h55, mee_pkg::CH_SEMI, 8'hAA);
		run_text(40);

		// Closing stretch at full rate with the reset markers.
		set_mode(1'b1, 8'd3, 8'd4, 8'd6);
		idle_on = 1'b0;
		run_text(60);

		settle();
		if (book.pending() != 0)
			book.report_mismatch($sformatf("%0d expected results never arrived",
				book.pending()));
		if (book.mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#1000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
